FILE: design/ds_twr_ranging_responder_unit_defines.svh
// ds_twr_ranging_responder_unit_defines.svh
// Assertion macros used by the ranging responder core (dstwr_core).
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef DS_TWR_RANGING_RESPONDER_UNIT_DEFINES_SVH
`define DS_TWR_RANGING_RESPONDER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DSTWR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSTWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dstwr_pkg.sv
// ----------------------------------------------------------------------------
// dstwr_pkg
// Types and codes shared by the two-way ranging responder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dstwr_pkg;

  localparam int unsigned StampW = 40;
  localparam int unsigned IntvW  = 32;
  localparam int unsigned CntW   = 32;

  // frame stage codes
  localparam logic [2:0] FRM_POLL  = 3'd1;
  localparam logic [2:0] FRM_FINAL = 3'd3;
  localparam logic [2:0] FRM_BCAST = 3'd5;

  // configuration register indexes
  localparam logic CFG_NODE_ADDR = 1'b0;
  localparam logic CFG_LISTEN_EN = 1'b1;

  typedef enum logic [2:0] {
    ACT_IGNORE  = 3'd0,
    ACT_RESPOND = 3'd1,
    ACT_REPORT  = 3'd2,
    ACT_BCAST   = 3'd3,
    ACT_ERROR   = 3'd4
  } action_e;

  typedef struct packed {
    logic              op_err;
    logic [2:0]        stage;
    logic [7:0]        dest_id;
    logic [StampW-1:0] rx_time;
    logic [StampW-1:0] tx_time;
  } item_t;

  typedef struct packed {
    action_e          action;
    logic [IntvW-1:0] round_time;
    logic [IntvW-1:0] reply_time;
    logic [CntW-1:0]  ranges_count;
    logic [CntW-1:0]  broadcast_count;
    logic [CntW-1:0]  error_count;
  } result_t;

endpackage

`default_nettype wire

FILE: design/ds_twr_ranging_responder_unit.sv
// ----------------------------------------------------------------------------
// ds_twr_ranging_responder_unit
// Responder side of double-sided two-way ranging, one event word per cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries receive events: tuser is the error flag, tdata the frame
//   (stage, destination id, rx stamp, tx stamp of the planned response).
//   m_axis returns one result word per event: tuser is the action code,
//   tdata the round and reply intervals and the three wrapping counters.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the node address (index 0) and
//   the listen enable (index 1); write only while no word is in flight.
// Path: an accepted word passes the input register, the decision logic,
//   then the result register, which presents its result on m_axis.
// Throughput: one word per cycle unless m_axis stalls, set by the decision
//   path (one 8-bit compare and two 32-bit subtractions) between the registers.
// Reset: both pipeline stages empty, counters and exchange state zero,
//   node address = 1, listen enable = 1.
// Stall: a held result keeps m_axis_tdata stable; an empty input stage still
//   takes one more word, then s_axis_tready drops until the result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ds_twr_ranging_responder_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [7:0]   cfg_data_i,
  // receive events
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // stage[2:0], dest_id[10:3],
                                           // rx_time[50:11], tx_time[90:51], 0
  input  wire logic [0:0]   s_axis_tuser,  // operation (1 = receive error)
  // results
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [159:0]      m_axis_tdata,  // round_time[31:0], reply_time[63:32],
                                           // ranges_count[95:64],
                                           // broadcast_count[127:96],
                                           // error_count[159:128]
  output logic [2:0]        m_axis_tuser   // action
);
  import dstwr_pkg::*;

  item_t   in_item, cur_item;
  result_t core_res, out_res;
  logic    cur_valid, can_load, fire;

  // unpack the incoming word
  always_comb begin
    in_item.op_err  = s_axis_tuser[0];
    in_item.stage   = s_axis_tdata[2:0];
    in_item.dest_id = s_axis_tdata[10:3];
    in_item.rx_time = s_axis_tdata[50:11];
    in_item.tx_time = s_axis_tdata[90:51];
  end

  // a word moves from input register to result register
  assign fire = cur_valid && can_load;

  dstwr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (fire),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  dstwr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (cur_item),
    .res_o      (core_res)
  );

  dstwr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (core_res),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tuser = out_res.action;
  assign m_axis_tdata = {out_res.error_count, out_res.broadcast_count,
                         out_res.ranges_count, out_res.reply_time,
                         out_res.round_time};

endmodule

`default_nettype wire

FILE: design/dstwr_in_reg.sv
// ----------------------------------------------------------------------------
// dstwr_in_reg
// Input register stage: captures one received-event word per cycle while free or emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dstwr_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire dstwr_pkg::item_t in_item_i,
  input  wire logic            take_i,
  output logic                 valid_o,
  output dstwr_pkg::item_t     item_o
);
  import dstwr_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // free, or emptied in this same cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_item_i;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: design/dstwr_core.sv
// ----------------------------------------------------------------------------
// dstwr_core
// Exchange state, counters, config registers and the per-word decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ds_twr_ranging_responder_unit_defines.svh"

module dstwr_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             fire_i,
  input  wire dstwr_pkg::item_t item_i,
  output dstwr_pkg::result_t    res_o
);
  import dstwr_pkg::*;

  logic [7:0]       anchor_q;
  logic             listen_q;
  logic             await_q, await_d;
  logic [IntvW-1:0] stamp_q, stamp_d;   // only the low bits reach round_time
  logic [IntvW-1:0] reply_q, reply_d;
  logic [CntW-1:0]  range_q, range_d;
  logic [CntW-1:0]  bcast_q, bcast_d;
  logic [CntW-1:0]  err_q, err_d;
  action_e          action;
  logic [IntvW-1:0] round;
  logic             mine;

  assign mine = (item_i.dest_id == anchor_q);

  always_comb begin
    await_d = await_q;
    stamp_d = stamp_q;
    reply_d = reply_q;
    range_d = range_q;
    bcast_d = bcast_q;
    err_d   = err_q;
    action  = ACT_IGNORE;
    round   = '0;
    if (item_i.op_err) begin
      err_d  = err_q + CntW'(1);
      action = ACT_ERROR;
    end else if (item_i.stage == FRM_BCAST && mine && listen_q) begin
      bcast_d = bcast_q + CntW'(1);
      await_d = 1'b0;
      action  = ACT_BCAST;
    end else if (item_i.stage == FRM_POLL && mine) begin
      stamp_d = item_i.tx_time[IntvW-1:0];
      reply_d = item_i.tx_time[IntvW-1:0] - item_i.rx_time[IntvW-1:0];
      await_d = 1'b1;
      action  = ACT_RESPOND;
    end else if (item_i.stage == FRM_FINAL && mine && await_q) begin
      round   = item_i.rx_time[IntvW-1:0] - stamp_q;
      range_d = range_q + CntW'(1);
      await_d = 1'b0;
      action  = ACT_REPORT;
    end
  end

  always_comb begin
    res_o.action          = action;
    res_o.round_time      = round;
    res_o.reply_time      = reply_d;
    res_o.ranges_count    = range_d;
    res_o.broadcast_count = bcast_d;
    res_o.error_count     = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= 8'd1;
      listen_q <= 1'b1;
      await_q  <= 1'b0;
      stamp_q  <= '0;
      reply_q  <= '0;
      range_q  <= '0;
      bcast_q  <= '0;
      err_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NODE_ADDR: anchor_q <= cfg_data_i;
          CFG_LISTEN_EN: listen_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (fire_i) begin
        await_q <= await_d;
        stamp_q <= stamp_d;
        reply_q <= reply_d;
        range_q <= range_d;
        bcast_q <= bcast_d;
        err_q   <= err_d;
      end
    end
  end

  `DSTWR_ASSERT_NEXT(a_err_inc, fire_i && item_i.op_err, err_q == $past(err_q) + CntW'(1), "error count did not advance")
  `DSTWR_ASSERT_IMPL(a_report_needs_await, fire_i && action == ACT_REPORT, await_q, "report without pending response")
  `DSTWR_ASSERT_NEXT(a_respond_arms, fire_i && action == ACT_RESPOND, await_q, "poll did not arm exchange")
  `DSTWR_ASSERT_NEXT(a_idle_holds, !fire_i, $stable(range_q) && $stable(bcast_q) && $stable(err_q), "counters moved without a word")

endmodule

`default_nettype wire

FILE: design/dstwr_out_reg.sv
// ----------------------------------------------------------------------------
// dstwr_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dstwr_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire dstwr_pkg::result_t res_i,
  output logic                    can_load_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dstwr_pkg::result_t      res_o
);
  import dstwr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: verif/tb_ds_twr_ranging_responder_unit.sv
// ----------------------------------------------------------------------------
// tb_ds_twr_ranging_responder_unit
// Self-checking bench for the two-way ranging responder.
// ----------------------------------------------------------------------------
// A scoreboard model of the responder (exchange flag, response stamp, reply
// interval, three wrapping counters, anchor id and listener enable) predicts
// one result word per accepted event word. A directed table covers reset
// values, stamp extremes, every stage code and the exchange corner cases.
// After it come random phases under several register settings and
// idle/stall patterns, built mostly from poll/final exchanges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ds_twr_ranging_responder_unit;
  import dstwr_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumPhases  = 8;
  localparam int PhaseWords = 50;
  localparam int HoldCycles = 150;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  // directed table row: event plus an optional hand-written result
  typedef struct packed {
    item_t   ev;
    logic    typed;
    result_t want;
  } dir_row_t;

  // DUT inputs, all known from time zero
  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic         cfg_idx_i     = 1'b0;
  logic [7:0]   cfg_data_i    = 8'h00;
  logic         s_axis_tvalid = 1'b0;
  logic [95:0]  s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = 1'b0;
  logic         m_axis_tready = 1'b0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [159:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  ds_twr_ranging_responder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // stage, dest_id, rx_time, tx_time, pad
    .s_axis_tuser  (s_axis_tuser),   // operation (receive error flag)
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // round, reply, ranges, broadcasts, errors
    .m_axis_tuser  (m_axis_tuser)    // action
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Responder model: mirrors the block's exchange state and registers
  // --------------------------------------------------------------------------
  logic [7:0]  my_anchor   = 8'd1;
  logic        listener_on = 1'b1;
  logic        final_due   = 1'b0;
  logic [39:0] resp_stamp  = '0;
  logic [31:0] reply_intv  = '0;
  logic [31:0] range_cnt   = '0;
  logic [31:0] bcast_cnt   = '0;
  logic [31:0] err_cnt     = '0;

  result_t    answers_due[$];   // result words still owed by the block
  dir_row_t   dir_rows[$];
  idle_mode_e idle_mode = IDLE_NONE;
  int         hold_left = 0;    // long receiver hold-off, counted down below
  int         mismatches = 0;
  int         events_sent = 0;
  int         words_checked = 0;
  int         cycle_cnt = 0;
  int         act_seen[0:4];

  logic [7:0] anchor_plan   [0:NumPhases-1];
  logic       listener_plan [0:NumPhases-1];
  idle_mode_e mode_plan     [0:NumPhases-1];

  // One event through the responder: updates the model state, returns the
  // result word the block must produce for it.
  function automatic result_t respond_to(input item_t ev);
    result_t     r;
    logic        mine;
    logic [39:0] diff;
    mine         = (ev.dest_id == my_anchor);
    r.action     = ACT_IGNORE;
    r.round_time = '0;
    if (ev.op_err) begin
      // frame fields don't matter, pending exchange survives
      err_cnt  = err_cnt + 1;
      r.action = ACT_ERROR;
    end else if (ev.stage == FRM_BCAST && mine && listener_on) begin
      bcast_cnt = bcast_cnt + 1;
      final_due = 1'b0;
      r.action  = ACT_BCAST;
    end else if (ev.stage == FRM_POLL && mine) begin
      // a new poll restarts any exchange in progress
      resp_stamp = ev.tx_time;
      diff       = ev.tx_time - ev.rx_time;
      reply_intv = diff[31:0];
      final_due  = 1'b1;
      r.action   = ACT_RESPOND;
    end else if (ev.stage == FRM_FINAL && mine && final_due) begin
      diff         = ev.rx_time - resp_stamp;
      r.round_time = diff[31:0];
      range_cnt    = range_cnt + 1;
      final_due    = 1'b0;
      r.action     = ACT_REPORT;
    end
    r.reply_time      = reply_intv;
    r.ranges_count    = range_cnt;
    r.broadcast_count = bcast_cnt;
    r.error_count     = err_cnt;
    return r;
  endfunction

  function automatic logic [39:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  function automatic item_t frame(input logic [2:0] stage, input logic [7:0] dest,
                                  input logic [39:0] rx, input logic [39:0] tx);
    item_t ev;
    ev.op_err  = 1'b0;
    ev.stage   = stage;
    ev.dest_id = dest;
    ev.rx_time = rx;
    ev.tx_time = tx;
    return ev;
  endfunction

  function automatic bit src_idles();
    case (idle_mode)
      IDLE_SRC:  return $urandom_range(0, 99) < 76;
      IDLE_BOTH: return $urandom_range(0, 99) < 36;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic add_row(input item_t ev, input logic typed, input action_e act,
                         input logic [31:0] round, input logic [31:0] reply,
                         input logic [31:0] ranges, input logic [31:0] bcasts,
                         input logic [31:0] errs);
    dir_row_t row;
    row.ev                   = ev;
    row.typed                = typed;
    row.want.action          = act;
    row.want.round_time      = round;
    row.want.reply_time      = reply;
    row.want.ranges_count    = ranges;
    row.want.broadcast_count = bcasts;
    row.want.error_count     = errs;
    dir_rows.push_back(row);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH word %0d %s: got %h want %h @%0t",
             words_checked, what, got, want, $time);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Sender side: drive at falling edge, accept at rising edge
  // --------------------------------------------------------------------------
  task automatic offer(input item_t ev);
    while (src_idles()) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, ev.tx_time, ev.rx_time, ev.dest_id, ev.stage};
    s_axis_tuser  <= ev.op_err;
    do @(posedge clk_i); while (!s_axis_tready);
    events_sent++;
  endtask

  task automatic send_event(input item_t ev);
    offer(ev);
    answers_due.push_back(respond_to(ev));
  endtask

  // Sender stops until every owed word is back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NODE_ADDR) my_anchor = val;
    else listener_on = val[0];
  endtask

  // Random traffic: mostly complete poll/final exchanges with random stamps,
  // the rest errors, broadcasts, orphan finals and foreign/odd frames.
  task automatic run_random(input int n);
    int          first;
    int          r;
    logic [39:0] rx;
    logic [39:0] tx;
    item_t       ev;
    first = events_sent;
    while (events_sent - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        rx = rand_stamp();
        tx = ($urandom_range(0, 3) == 0) ? rand_stamp() : rx + $urandom_range(0, 1 << 20);
        send_event(frame(FRM_POLL, my_anchor, rx, tx));
        if ($urandom_range(0, 99) < 30) begin
          ev = frame($urandom_range(0, 7), $urandom, rand_stamp(), rand_stamp());
          ev.op_err = $urandom_range(0, 1);
          send_event(ev);
        end
        rx = ($urandom_range(0, 3) == 0) ? rand_stamp() : tx + $urandom_range(0, 1 << 20);
        send_event(frame(FRM_FINAL, my_anchor, rx, rand_stamp()));
        if ($urandom_range(0, 99) < 20)
          send_event(frame(FRM_BCAST, my_anchor, rand_stamp(), rand_stamp()));
      end else if (r < 70) begin
        ev = frame($urandom_range(0, 7), $urandom, rand_stamp(), rand_stamp());
        ev.op_err = 1'b1;
        send_event(ev);
      end else if (r < 80) begin
        send_event(frame(FRM_BCAST, my_anchor, rand_stamp(), rand_stamp()));
      end else if (r < 90) begin
        send_event(frame(FRM_FINAL, my_anchor, rand_stamp(), rand_stamp()));
      end else begin
        send_event(frame($urandom_range(0, 7), $urandom_range(0, 1) ? my_anchor : $urandom,
                         rand_stamp(), rand_stamp()));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: ready changes at falling edge; a pending hold-off wins
  // over the random stall pattern.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      case (idle_mode)
        IDLE_SINK: m_axis_tready <= ($urandom_range(0, 99) >= 76);
        IDLE_BOTH: m_axis_tready <= ($urandom_range(0, 99) >= 36);
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Result checker: every accepted word against the oldest owed word
  always @(posedge clk_i) begin : check_words
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        note_mismatch("word with nothing owed", m_axis_tdata[63:0], '0);
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tuser != want.action)
          note_mismatch("action", m_axis_tuser, want.action);
        if (m_axis_tdata[31:0] != want.round_time)
          note_mismatch("round_time", m_axis_tdata[31:0], want.round_time);
        if (m_axis_tdata[63:32] != want.reply_time)
          note_mismatch("reply_time", m_axis_tdata[63:32], want.reply_time);
        if (m_axis_tdata[95:64] != want.ranges_count)
          note_mismatch("ranges_count", m_axis_tdata[95:64], want.ranges_count);
        if (m_axis_tdata[127:96] != want.broadcast_count)
          note_mismatch("broadcast_count", m_axis_tdata[127:96], want.broadcast_count);
        if (m_axis_tdata[159:128] != want.error_count)
          note_mismatch("error_count", m_axis_tdata[159:128], want.error_count);
        if (want.action <= ACT_ERROR) act_seen[want.action]++;
        words_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still owed",
               cycle_cnt, answers_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    item_t ev;
    for (int a = 0; a <= 4; a++) act_seen[a] = 0;

    // register plan per random phase: address and listener extremes first
    anchor_plan[0] = 8'h00;  listener_plan[0] = 1'b0;  mode_plan[0] = IDLE_NONE;
    anchor_plan[1] = 8'hFF;  listener_plan[1] = 1'b1;  mode_plan[1] = IDLE_SRC;
    anchor_plan[2] = 8'h01;  listener_plan[2] = 1'b1;  mode_plan[2] = IDLE_SINK;
    anchor_plan[3] = $urandom;
    listener_plan[3] = 1'b0; mode_plan[3] = IDLE_BOTH;
    anchor_plan[4] = 8'h80;  listener_plan[4] = 1'b1;  mode_plan[4] = IDLE_NONE;
    anchor_plan[5] = $urandom;
    listener_plan[5] = $urandom_range(0, 1);           mode_plan[5] = IDLE_SRC;
    anchor_plan[6] = 8'h7F;  listener_plan[6] = 1'b0;  mode_plan[6] = IDLE_SINK;
    anchor_plan[7] = 8'hFF;  listener_plan[7] = 1'b1;  mode_plan[7] = IDLE_BOTH;

    // Directed table, reset settings (anchor 1, listener on).
    // Typed rows follow directly from the zeroed state.
    ev = frame(FRM_BCAST, 8'd1, '1, '1);  ev.op_err = 1'b1;   // error ignores fields
    add_row(ev, 1'b1, ACT_ERROR, 0, 0, 0, 0, 1);
    add_row(frame(3'd0, 8'd1, '0, '0), 1'b1, ACT_IGNORE, 0, 0, 0, 0, 1);
    // final with no response outstanding
    add_row(frame(FRM_FINAL, 8'd1, '0, '0), 1'b1, ACT_IGNORE, 0, 0, 0, 0, 1);
    add_row(frame(FRM_BCAST, 8'd1, '0, '0), 1'b1, ACT_BCAST, 0, 0, 0, 1, 1);
    // stamp extremes: reply and round both wrap
    add_row(frame(FRM_POLL, 8'd1, '0, '1), 1'b1, ACT_RESPOND, 0, 32'hFFFF_FFFF, 0, 1, 1);
    add_row(frame(FRM_FINAL, 8'd1, '0, rand_stamp()), 1'b1,
            ACT_REPORT, 1, 32'hFFFF_FFFF, 1, 1, 1);
    add_row(frame(FRM_POLL, 8'd1, '1, '0), 1'b1, ACT_RESPOND, 0, 1, 1, 1, 1);
    // error in mid exchange keeps it open
    ev = frame(FRM_POLL, 8'd1, rand_stamp(), rand_stamp());  ev.op_err = 1'b1;
    add_row(ev, 1'b0, ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_FINAL, 8'd2, rand_stamp(), '0), 1'b0, ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(3'd7, 8'd1, '1, '1), 1'b0, ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_FINAL, 8'd1, 40'h12_3456_789A, '0), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_POLL, 8'hFF, rand_stamp(), rand_stamp()), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_POLL, 8'h00, rand_stamp(), rand_stamp()), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    // broadcast closes an open exchange, the final after it is ignored
    add_row(frame(FRM_POLL, 8'd1, 40'h00_0000_1000, 40'h00_0000_5000), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_BCAST, 8'd1, rand_stamp(), rand_stamp()), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_FINAL, 8'd1, 40'h00_0000_9000, '0), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(3'd2, 8'd1, rand_stamp(), rand_stamp()), 1'b0, ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(3'd4, 8'd1, rand_stamp(), rand_stamp()), 1'b0, ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(3'd6, 8'd1, rand_stamp(), rand_stamp()), 1'b0, ACT_IGNORE, 0, 0, 0, 0, 0);
    // second poll restarts the exchange with a new stamp
    add_row(frame(FRM_POLL, 8'd1, 40'hAA_0000_0000, 40'hAA_0010_0000), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_POLL, 8'd1, 40'h55_FFFF_0000, 40'h56_0000_1000), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_FINAL, 8'd1, 40'h56_0100_0000, rand_stamp()), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);
    add_row(frame(FRM_BCAST, 8'd3, rand_stamp(), rand_stamp()), 1'b0,
            ACT_IGNORE, 0, 0, 0, 0, 0);

    // reset held from time zero, released at a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      result_t modeled;
      offer(dir_rows[i].ev);
      modeled = respond_to(dir_rows[i].ev);
      answers_due.push_back(dir_rows[i].typed ? dir_rows[i].want : modeled);
    end
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CFG_NODE_ADDR, anchor_plan[p]);
      write_reg(CFG_LISTEN_EN, {7'b0, listener_plan[p]});
      idle_mode = mode_plan[p];
      if (p == 0) begin
        // back-to-back words against a long hold-off fill the pipeline
        run_random(10);
        hold_left = HoldCycles;
        run_random(PhaseWords - 10);
      end else if (p == 4) begin
        // sender pauses mid phase until the block is empty
        run_random(PhaseWords / 2);
        drain();
        run_random(PhaseWords / 2);
      end else begin
        run_random(PhaseWords);
      end
      drain();
    end

    $display("covered %0d event words over %0d register settings, %0d result words checked",
             events_sent, NumPhases + 1, words_checked);
    $display("actions seen: ignore %0d, respond %0d, report %0d, broadcast %0d, error %0d",
             act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: ds_twr_ranging_responder_unit.f
+incdir+design
design/dstwr_pkg.sv
design/dstwr_in_reg.sv
design/dstwr_core.sv
design/dstwr_out_reg.sv
design/ds_twr_ranging_responder_unit.sv
verif/tb_ds_twr_ranging_responder_unit.sv
